// ===== rtl/fwbcc_pkg.sv =====
// Shared types, constants and codes for the FIFO write-back cache controller.
// No dependencies; every other file of the block except fwbcc_ram uses this package.
`default_nettype none

package fwbcc_pkg;

   // Field widths of the transaction payloads
   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   localparam int STAT_W = 32;

   // Configuration register widths and reset values
   localparam int CFG_CAP_W  = 5;
   localparam int CFG_COST_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CFG_CAP_W-1:0]  CAPACITY_RST    = 5'd4;
   localparam logic [CFG_COST_W-1:0] HIT_COST_RST    = 16'd1;
   localparam logic [CFG_COST_W-1:0] MEMORY_COST_RST = 16'd100;

   // Default line store depth
   localparam int DEF_MAX_LINES = 16;

   // Access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY    = 2'd0,
      CSR_HIT_COST    = 2'd1,
      CSR_MEMORY_COST = 2'd2
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HEAD,
      ST_UPDATE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// ===== rtl/fwbcc_req_if.sv =====
// Request channel: one cache access transaction with valid/ready handshake.
// Depends on fwbcc_pkg for field widths.
`default_nettype none

interface fwbcc_req_if;
   import fwbcc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [ADDR_W-1:0]        address;
   logic signed [DATA_W-1:0] write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/fwbcc_rsp_if.sv =====
// Response channel: access outcome, write-back and statistics per transaction.
// Depends on fwbcc_pkg for field widths.
`default_nettype none

interface fwbcc_rsp_if;
   import fwbcc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     tag_found;
   logic                     writeback_valid;
   logic [ADDR_W-1:0]        writeback_address;
   logic signed [DATA_W-1:0] writeback_data;
   logic [STAT_W-1:0]        read_hits;
   logic [STAT_W-1:0]        read_misses;
   logic [STAT_W-1:0]        write_hits;
   logic [STAT_W-1:0]        write_misses;
   logic [STAT_W-1:0]        hit_time;
   logic [STAT_W-1:0]        miss_time;

   modport source (output valid, output tag_found, output writeback_valid,
                   output writeback_address, output writeback_data,
                   output read_hits, output read_misses, output write_hits,
                   output write_misses, output hit_time, output miss_time,
                   input ready);
   modport sink   (input valid, input tag_found, input writeback_valid,
                   input writeback_address, input writeback_data,
                   input read_hits, input read_misses, input write_hits,
                   input write_misses, input hit_time, input miss_time,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/fwbcc_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none

module fwbcc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fwbcc_ctrl.sv =====
// Controller state machine: sequences accept, tag scan, head read and update.
// Depends on fwbcc_pkg for state, command and status types.
`default_nettype none

module fwbcc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire fwbcc_pkg::ctrl_sts_type sts,
   output fwbcc_pkg::ctrl_cmd_type      cmd
);
   import fwbcc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.update = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // hold off requests while reset is asserted
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            // head line read is in flight
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register is free
            if (sts.rsp_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/fwbcc_dpath.sv =====
// Datapath: configuration registers, line stores, FIFO pointers, statistics
// and the result register. Depends on fwbcc_pkg, fwbcc_ram and fwbcc_rsp_if.
`default_nettype none

module fwbcc_dpath #(
   parameter int MAX_LINES = fwbcc_pkg::DEF_MAX_LINES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fwbcc_pkg::ctrl_cmd_type              cmd,
   output fwbcc_pkg::ctrl_sts_type                   sts,
   input  wire logic                                 req_operation,
   input  wire logic [fwbcc_pkg::ADDR_W-1:0]         req_address,
   input  wire logic signed [fwbcc_pkg::DATA_W-1:0]  req_write_data,
   input  wire logic                                 csr_we,
   input  wire logic [fwbcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fwbcc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   fwbcc_rsp_if.source                               rsp_chan
);
   import fwbcc_pkg::*;

   localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CNT_W  = $clog2(MAX_LINES + 1);
   localparam int WIDE_W = (CNT_W > CFG_CAP_W) ? CNT_W : CFG_CAP_W;
   localparam int ADD_W  = CFG_COST_W + 1;

   // Offset from the FIFO head, wrapped into the line store
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(MAX_LINES)) begin
         sum = sum - (CNT_W+1)'(MAX_LINES);
      end
      return IDX_W'(sum);
   endfunction

   // Saturating 32-bit accumulate
   function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                 input logic [ADD_W-1:0]  b);
      logic [STAT_W:0] sum;
      sum = {1'b0, a} + (STAT_W+1)'(b);
      return sum[STAT_W] ? {STAT_W{1'b1}} : sum[STAT_W-1:0];
   endfunction

   // Configuration
   logic [CFG_CAP_W-1:0]  capacity_ff, capacity_in;
   logic [CFG_COST_W-1:0] hit_cost_ff, hit_cost_in;
   logic [CFG_COST_W-1:0] memory_cost_ff, memory_cost_in;

   // Current transaction
   logic              op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;

   // Scan state
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;

   // FIFO bookkeeping
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dirty_ff [MAX_LINES];
   logic             dirty_in [MAX_LINES];

   // Statistics
   logic [STAT_W-1:0] rd_hit_ff, rd_hit_in;
   logic [STAT_W-1:0] rd_miss_ff, rd_miss_in;
   logic [STAT_W-1:0] wr_hit_ff, wr_hit_in;
   logic [STAT_W-1:0] wr_miss_ff, wr_miss_in;
   logic [STAT_W-1:0] hit_time_ff, hit_time_in;
   logic [STAT_W-1:0] miss_time_ff, miss_time_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_found_ff, out_found_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [DATA_W-1:0] wb_data_ff, wb_data_in;

   // Line stores
   logic              tag_we;
   logic [IDX_W-1:0]  tag_waddr;
   logic [IDX_W-1:0]  tag_raddr;
   logic [ADDR_W-1:0] tag_rdata;
   logic              val_we;
   logic [IDX_W-1:0]  val_waddr;
   logic [DATA_W-1:0] val_wdata;
   logic [DATA_W-1:0] val_rdata;

   // Combinational helpers
   logic [WIDE_W-1:0] cap_wide;
   logic [IDX_W-1:0]  issue_slot;
   logic              match_now;
   logic              scan_done;
   logic              is_wr;
   logic              full;
   logic              evict;
   logic [IDX_W-1:0]  new_slot;
   logic [IDX_W-1:0]  head_next;
   logic [IDX_W:0]    head_inc;
   logic              head_written;
   logic              hit_dirty;
   logic              wb;
   logic              rd_hit, rd_miss, wr_hit, wr_miss;
   logic [ADD_W-1:0]  hit_add, miss_add;

   fwbcc_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LINES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (addr_ff),
      .rd_addr (tag_raddr),
      .rd_data (tag_rdata)
   );

   fwbcc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LINES)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (head_ff),
      .rd_data (val_rdata)
   );

   // Clamp capacity into 1..MAX_LINES
   assign cap_wide = WIDE_W'(capacity_ff);

   // Scan: issue one tag read a cycle, compare each tag in the cycle after its read
   assign issue_slot = slot_of(head_ff, issue_ff);
   assign match_now  = pend_ff && (tag_rdata == addr_ff);
   assign scan_done  = match_now || (issue_ff == count_ff);
   assign tag_raddr  = cmd.scan ? issue_slot : head_ff;

   // Update decisions
   assign is_wr        = (op_ff == OP_WRITE);
   assign full         = (count_ff == CNT_W'(MAX_LINES));
   assign evict        = found_ff ? (count_ff > cap_ff) : (full || (count_ff >= cap_ff));
   assign new_slot     = full ? head_ff : slot_of(head_ff, count_ff);
   assign head_inc     = (IDX_W+1)'(head_ff) + (IDX_W+1)'(1);
   assign head_next    = (head_inc == (IDX_W+1)'(MAX_LINES)) ? '0 : IDX_W'(head_inc);
   assign head_written = found_ff && is_wr && (hit_slot_ff == head_ff);
   assign hit_dirty    = dirty_ff[hit_slot_ff];
   assign wb           = evict && (head_written || dirty_ff[head_ff]);

   assign rd_hit  = found_ff && !is_wr;
   assign rd_miss = !found_ff && !is_wr;
   assign wr_hit  = found_ff && is_wr && hit_dirty;
   assign wr_miss = is_wr && !wr_hit;

   assign hit_add  = (rd_hit || wr_hit) ? ADD_W'(hit_cost_ff) : '0;
   assign miss_add = (rd_miss ? ADD_W'(memory_cost_ff) : '0)
                   + (wb ? ADD_W'(memory_cost_ff) : '0);

   // Line store writes
   assign tag_we    = cmd.update && !found_ff;
   assign tag_waddr = new_slot;
   assign val_we    = cmd.update && (!found_ff || is_wr);
   assign val_waddr = found_ff ? hit_slot_ff : new_slot;
   assign val_wdata = is_wr ? wdata_ff : '0;

   assign sts.scan_done = scan_done;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // Next values
   always_comb begin
      capacity_in    = capacity_ff;
      hit_cost_in    = hit_cost_ff;
      memory_cost_in = memory_cost_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      wdata_in       = wdata_ff;
      cap_in         = cap_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      cmp_slot_in    = cmp_slot_ff;
      found_in       = found_ff;
      hit_slot_in    = hit_slot_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      dirty_in       = dirty_ff;
      rd_hit_in      = rd_hit_ff;
      rd_miss_in     = rd_miss_ff;
      wr_hit_in      = wr_hit_ff;
      wr_miss_in     = wr_miss_ff;
      hit_time_in    = hit_time_ff;
      miss_time_in   = miss_time_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_found_in   = out_found_ff;
      wb_valid_in    = wb_valid_ff;
      wb_addr_in     = wb_addr_ff;
      wb_data_in     = wb_data_ff;

      // Drop the result once it is taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Latch the accepted transaction
      if (cmd.load) begin
         op_in    = req_operation;
         addr_in  = req_address;
         wdata_in = req_write_data;
         if (cap_wide == '0) begin
            cap_in = CNT_W'(1);
         end else if (cap_wide > WIDE_W'(MAX_LINES)) begin
            cap_in = CNT_W'(MAX_LINES);
         end else begin
            cap_in = CNT_W'(cap_wide);
         end
         issue_in = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end

      // Advance the tag scan
      if (cmd.scan) begin
         pend_in     = !scan_done;
         issue_in    = scan_done ? issue_ff : issue_ff + CNT_W'(1);
         cmp_slot_in = issue_slot;
         if (match_now) begin
            found_in    = 1'b1;
            hit_slot_in = cmp_slot_ff;
         end
      end

      // Apply the access, evict and post the result
      if (cmd.update) begin
         if (found_ff && is_wr) begin
            dirty_in[hit_slot_ff] = 1'b1;
         end
         if (evict) begin
            dirty_in[head_ff] = 1'b0;
            head_in           = head_next;
         end
         if (!found_ff) begin
            dirty_in[new_slot] = is_wr;
         end

         if (found_ff) begin
            count_in = evict ? count_ff - CNT_W'(1) : count_ff;
         end else if (!full && !evict) begin
            count_in = count_ff + CNT_W'(1);
         end

         rd_hit_in    = sat_add(rd_hit_ff, ADD_W'(rd_hit));
         rd_miss_in   = sat_add(rd_miss_ff, ADD_W'(rd_miss));
         wr_hit_in    = sat_add(wr_hit_ff, ADD_W'(wr_hit));
         wr_miss_in   = sat_add(wr_miss_ff, ADD_W'(wr_miss));
         hit_time_in  = sat_add(hit_time_ff, hit_add);
         miss_time_in = sat_add(miss_time_ff, miss_add);

         rsp_valid_in = 1'b1;
         out_found_in = found_ff;
         wb_valid_in  = wb;
         wb_addr_in   = wb ? tag_rdata : '0;
         wb_data_in   = wb ? (head_written ? wdata_ff : val_rdata) : '0;
      end

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY:    capacity_in    = csr_wdata[CFG_CAP_W-1:0];
            CSR_HIT_COST:    hit_cost_in    = csr_wdata[CFG_COST_W-1:0];
            CSR_MEMORY_COST: memory_cost_in = csr_wdata[CFG_COST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RST;
         hit_cost_ff    <= HIT_COST_RST;
         memory_cost_ff <= MEMORY_COST_RST;
         head_ff        <= '0;
         count_ff       <= '0;
         for (int i = 0; i < MAX_LINES; i++) begin
            dirty_ff[i] <= 1'b0;
         end
         rd_hit_ff      <= '0;
         rd_miss_ff     <= '0;
         wr_hit_ff      <= '0;
         wr_miss_ff     <= '0;
         hit_time_ff    <= '0;
         miss_time_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         pend_ff        <= 1'b0;
      end else begin
         capacity_ff    <= capacity_in;
         hit_cost_ff    <= hit_cost_in;
         memory_cost_ff <= memory_cost_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         dirty_ff       <= dirty_in;
         rd_hit_ff      <= rd_hit_in;
         rd_miss_ff     <= rd_miss_in;
         wr_hit_ff      <= wr_hit_in;
         wr_miss_ff     <= wr_miss_in;
         hit_time_ff    <= hit_time_in;
         miss_time_ff   <= miss_time_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_ff        <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      cap_ff       <= cap_in;
      issue_ff     <= issue_in;
      cmp_slot_ff  <= cmp_slot_in;
      found_ff     <= found_in;
      hit_slot_ff  <= hit_slot_in;
      out_found_ff <= out_found_in;
      wb_valid_ff  <= wb_valid_in;
      wb_addr_ff   <= wb_addr_in;
      wb_data_ff   <= wb_data_in;
   end

   // Drive the response channel
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.tag_found         = out_found_ff;
   assign rsp_chan.writeback_valid   = wb_valid_ff;
   assign rsp_chan.writeback_address = wb_addr_ff;
   assign rsp_chan.writeback_data    = wb_data_ff;
   assign rsp_chan.read_hits         = rd_hit_ff;
   assign rsp_chan.read_misses       = rd_miss_ff;
   assign rsp_chan.write_hits        = wr_hit_ff;
   assign rsp_chan.write_misses      = wr_miss_ff;
   assign rsp_chan.hit_time          = hit_time_ff;
   assign rsp_chan.miss_time         = miss_time_ff;

endmodule

`default_nettype wire

// ===== rtl/fifo_write_back_cache_controller_top.sv =====
// Top level of the fully associative FIFO write-back cache controller.
// Depends on fwbcc_pkg, fwbcc_req_if, fwbcc_rsp_if, fwbcc_ctrl and fwbcc_dpath.
//
//   channel   direction  handshake                  payload
//   req_chan  in         valid/ready                operation, address, write_data
//   rsp_chan  out        valid/ready                tag_found, write-back, statistics
//   csr_*     in         csr_we, no back-pressure   csr_index, csr_wdata
//
// From one accept to the next, the tag scan reads one tag per cycle, compares
// each tag in the cycle after its read and stops at a hit or after the last
// line; then the FIFO head line is read, and then the update is applied and
// the result is loaded.
// A new transaction is accepted while rsp_chan stalls; its update waits until
// the earlier result is taken. Reset is synchronous, holds req_chan not ready.
`default_nettype none

module fifo_write_back_cache_controller_top #(
   parameter int MAX_LINES = fwbcc_pkg::DEF_MAX_LINES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   fwbcc_req_if.sink                             req_chan,
   fwbcc_rsp_if.source                           rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [fwbcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fwbcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fwbcc_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         req_ready;

   fwbcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fwbcc_dpath #(.MAX_LINES(MAX_LINES)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_chan.operation),
      .req_address    (req_chan.address),
      .req_write_data (req_chan.write_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_chan       (rsp_chan)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire
